// ===== design/opt_pkg.sv =====
// Shared types and constants for the occlusion pulse tachometer.
// Used by opt_div, opt_dpath, opt_ctrl and occlusion_pulse_tachometer.
// No dependencies.
package opt_pkg;

    // Field widths
    localparam int DIST_W  = 16;
    localparam int TIME_W  = 32;
    localparam int NUM_W   = 24;
    localparam int SPEED_W = 16;
    localparam int CFG_W   = 24;
    localparam int CFG_IDX_W = 4;

    // Divider step count: one quotient bit per step
    localparam int DIV_STEPS = NUM_W;
    localparam int DIV_CNT_W = $clog2(DIV_STEPS + 1);

    // Configuration register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_COVER_THRESHOLD = 4'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_GLITCH_LIMIT    = 4'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_RPM_NUMERATOR   = 4'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_OMEGA_NUMERATOR = 4'd3;

    // Configuration reset values
    localparam logic [DIST_W-1:0] RST_COVER_THRESHOLD = 16'd1000;
    localparam logic [15:0]       RST_GLITCH_LIMIT    = 16'd10;
    localparam logic [NUM_W-1:0]  RST_RPM_NUMERATOR   = 24'd320000;
    localparam logic [NUM_W-1:0]  RST_OMEGA_NUMERATOR = 24'd536165;

    // Controller to datapath commands
    typedef struct packed {
        logic capture;    // latch the input sample
        logic set_cover;  // mark covered and record entry time
        logic clr_cover;  // end the current cover
        logic div_start;  // latch cover time and start both divisions
        logic load_out;   // move the finished result to the output register
    } opt_cmd_t;

    // Datapath to controller status
    typedef struct packed {
        logic below;      // sample distance below threshold
        logic covered;    // a cover is in progress
        logic keep;       // cover time exceeds the glitch limit
        logic div_done;   // quotients are ready
        logic out_free;   // output register can take a result
    } opt_sts_t;

endpackage

// ===== design/opt_div.sv =====
// Two-lane restoring divider: both numerators over one shared cover time.
// Depends on opt_pkg. One quotient bit per lane per cycle, saturated to 16 bits.
module opt_div
    import opt_pkg::*;
(
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                start,
    input  logic [NUM_W-1:0]    num_a,
    input  logic [NUM_W-1:0]    num_b,
    input  logic [TIME_W-1:0]   den,
    output logic                done,
    output logic [SPEED_W-1:0]  quo_a,
    output logic [SPEED_W-1:0]  quo_b
);

    logic [DIV_CNT_W-1:0] count_reg, count_next;
    logic                 done_reg, done_next;
    logic [TIME_W-1:0]    den_reg;
    logic [NUM_W-1:0]     shf_a_reg, shf_a_next;
    logic [NUM_W-1:0]     shf_b_reg, shf_b_next;
    logic [NUM_W-1:0]     rem_a_reg, rem_a_next;
    logic [NUM_W-1:0]     rem_b_reg, rem_b_next;

    logic [NUM_W:0]       part_a, part_b;
    logic [TIME_W:0]      diff_a, diff_b;
    logic                 ge_a, ge_b;

    // One restoring step per lane: shift in the next numerator bit, try subtract
    always_comb begin
        part_a = {rem_a_reg, shf_a_reg[NUM_W-1]};
        part_b = {rem_b_reg, shf_b_reg[NUM_W-1]};
        diff_a = {{(TIME_W-NUM_W){1'b0}}, part_a} - {1'b0, den_reg};
        diff_b = {{(TIME_W-NUM_W){1'b0}}, part_b} - {1'b0, den_reg};
        ge_a   = !diff_a[TIME_W];
        ge_b   = !diff_b[TIME_W];

        count_next = count_reg;
        done_next  = 1'b0;
        shf_a_next = shf_a_reg;
        shf_b_next = shf_b_reg;
        rem_a_next = rem_a_reg;
        rem_b_next = rem_b_reg;

        if (start) begin
            count_next = DIV_CNT_W'(DIV_STEPS);
            shf_a_next = num_a;
            shf_b_next = num_b;
            rem_a_next = '0;
            rem_b_next = '0;
        end else if (count_reg != '0) begin
            count_next = count_reg - 1'b1;
            done_next  = (count_reg == DIV_CNT_W'(1));
            shf_a_next = {shf_a_reg[NUM_W-2:0], ge_a};
            shf_b_next = {shf_b_reg[NUM_W-2:0], ge_b};
            rem_a_next = ge_a ? diff_a[NUM_W-1:0] : part_a[NUM_W-1:0];
            rem_b_next = ge_b ? diff_b[NUM_W-1:0] : part_b[NUM_W-1:0];
        end
    end

    // Hold step count and done pulse
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            count_reg <= '0;
            done_reg  <= 1'b0;
        end else begin
            count_reg <= count_next;
            done_reg  <= done_next;
        end
    end

    // Advance the working registers
    always_ff @(posedge aclk) begin
        if (start) begin
            den_reg <= den;
        end
        shf_a_reg <= shf_a_next;
        shf_b_reg <= shf_b_next;
        rem_a_reg <= rem_a_next;
        rem_b_reg <= rem_b_next;
    end

    // Quotient sits in the shift registers after the last step; saturate
    assign quo_a = (shf_a_reg[NUM_W-1:SPEED_W] != '0) ? '1 : shf_a_reg[SPEED_W-1:0];
    assign quo_b = (shf_b_reg[NUM_W-1:SPEED_W] != '0) ? '1 : shf_b_reg[SPEED_W-1:0];
    assign done  = done_reg;

endmodule

// ===== design/opt_dpath.sv =====
// Datapath: configuration registers, cover tracking, divider and output register.
// Depends on opt_pkg and opt_div.
module opt_dpath
    import opt_pkg::*;
(
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  cfg_wr_en,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_W-1:0]      cfg_wdata,
    input  logic [DIST_W-1:0]     s_distance,
    input  logic [TIME_W-1:0]     s_time_ms,
    input  opt_cmd_t              cmd,
    output opt_sts_t              sts,
    input  logic                  m_ready,
    output logic                  m_valid,
    output logic [TIME_W-1:0]     m_cover_ms,
    output logic [SPEED_W-1:0]    m_omega_q8,
    output logic [SPEED_W-1:0]    m_rpm_now_q4,
    output logic [SPEED_W-1:0]    m_rpm_prev_q4,
    output logic [SPEED_W-1:0]    m_rpm_min_q4,
    output logic                  m_prev_valid
);

    // Configuration
    logic [DIST_W-1:0]  threshold_reg;
    logic [15:0]        glitch_reg;
    logic [NUM_W-1:0]   rpm_num_reg;
    logic [NUM_W-1:0]   omega_num_reg;

    // Sample and cover state
    logic [DIST_W-1:0]  dist_reg;
    logic [TIME_W-1:0]  time_reg;
    logic               covered_reg;
    logic [TIME_W-1:0]  entry_reg;
    logic [TIME_W-1:0]  cover_reg;
    logic               have_prev_reg;
    logic [SPEED_W-1:0] prev_rpm_reg;

    // Output register
    logic               m_valid_reg;
    logic [TIME_W-1:0]  out_cover_reg;
    logic [SPEED_W-1:0] out_omega_reg;
    logic [SPEED_W-1:0] out_rpm_reg;
    logic [SPEED_W-1:0] out_prev_reg;
    logic [SPEED_W-1:0] out_min_reg;
    logic               out_pv_reg;

    logic [TIME_W-1:0]  cover_diff;
    logic               div_done;
    logic [SPEED_W-1:0] omega_q;
    logic [SPEED_W-1:0] rpm_q;
    logic [SPEED_W-1:0] prev_sel;
    logic [SPEED_W-1:0] min_sel;

    // Write configuration registers; unknown indexes are ignored
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            threshold_reg <= RST_COVER_THRESHOLD;
            glitch_reg    <= RST_GLITCH_LIMIT;
            rpm_num_reg   <= RST_RPM_NUMERATOR;
            omega_num_reg <= RST_OMEGA_NUMERATOR;
        end else if (cfg_wr_en) begin
            case (cfg_index)
                CFG_COVER_THRESHOLD: threshold_reg <= cfg_wdata[DIST_W-1:0];
                CFG_GLITCH_LIMIT:    glitch_reg    <= cfg_wdata[15:0];
                CFG_RPM_NUMERATOR:   rpm_num_reg   <= cfg_wdata[NUM_W-1:0];
                CFG_OMEGA_NUMERATOR: omega_num_reg <= cfg_wdata[NUM_W-1:0];
                default: ;
            endcase
        end
    end

    // Capture the accepted sample; latch the cover time when a division starts
    always_ff @(posedge aclk) begin
        if (cmd.capture) begin
            dist_reg <= s_distance;
            time_reg <= s_time_ms;
        end
        if (cmd.div_start) begin
            cover_reg <= cover_diff;
        end
    end

    // Cover time modulo 2^32
    assign cover_diff = time_reg - entry_reg;

    // Track cover entry and the last kept rpm
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            covered_reg   <= 1'b0;
            entry_reg     <= '0;
            have_prev_reg <= 1'b0;
            prev_rpm_reg  <= '0;
        end else begin
            if (cmd.set_cover) begin
                covered_reg <= 1'b1;
                entry_reg   <= time_reg;
            end else if (cmd.clr_cover) begin
                covered_reg <= 1'b0;
            end
            if (cmd.load_out) begin
                have_prev_reg <= 1'b1;
                prev_rpm_reg  <= rpm_q;
            end
        end
    end

    opt_div u_div (
        .aclk    (aclk),
        .aresetn (aresetn),
        .start   (cmd.div_start),
        .num_a   (omega_num_reg),
        .num_b   (rpm_num_reg),
        .den     (cover_diff),
        .done    (div_done),
        .quo_a   (omega_q),
        .quo_b   (rpm_q)
    );

    // Previous and minimum rpm
    assign prev_sel = have_prev_reg ? prev_rpm_reg : '0;
    assign min_sel  = (have_prev_reg && (prev_rpm_reg < rpm_q)) ? prev_rpm_reg : rpm_q;

    // Output register valid: set on load, drop on transfer
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (cmd.load_out) begin
            m_valid_reg <= 1'b1;
        end else if (m_ready) begin
            m_valid_reg <= 1'b0;
        end
    end

    // Output payload
    always_ff @(posedge aclk) begin
        if (cmd.load_out) begin
            out_cover_reg <= cover_reg;
            out_omega_reg <= omega_q;
            out_rpm_reg   <= rpm_q;
            out_prev_reg  <= prev_sel;
            out_min_reg   <= min_sel;
            out_pv_reg    <= have_prev_reg;
        end
    end

    // Status to the controller
    always_comb begin
        sts.below    = (dist_reg < threshold_reg);
        sts.covered  = covered_reg;
        sts.keep     = (cover_diff > {{(TIME_W-16){1'b0}}, glitch_reg});
        sts.div_done = div_done;
        sts.out_free = !m_valid_reg || m_ready;
    end

    assign m_valid       = m_valid_reg;
    assign m_cover_ms    = out_cover_reg;
    assign m_omega_q8    = out_omega_reg;
    assign m_rpm_now_q4  = out_rpm_reg;
    assign m_rpm_prev_q4 = out_prev_reg;
    assign m_rpm_min_q4  = out_min_reg;
    assign m_prev_valid  = out_pv_reg;

endmodule

// ===== design/opt_ctrl.sv =====
// Controller: sequences capture, evaluation, division and result load.
// Depends on opt_pkg.
module opt_ctrl
    import opt_pkg::*;
(
    input  logic      aclk,
    input  logic      aresetn,
    input  logic      s_valid,
    output logic      s_ready,
    input  opt_sts_t  sts,
    output opt_cmd_t  cmd
);

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_EVAL,
        ST_DIV,
        ST_LOAD
    } state_t;

    state_t state_reg, state_next;
    logic   s_ready_reg, s_ready_next;

    // Next state and commands
    always_comb begin
        state_next   = state_reg;
        s_ready_next = s_ready_reg;
        cmd          = '0;
        case (state_reg)
            ST_IDLE: begin
                if (s_valid && s_ready_reg) begin
                    cmd.capture  = 1'b1;
                    state_next   = ST_EVAL;
                    s_ready_next = 1'b0;
                end
            end
            ST_EVAL: begin
                if (sts.below) begin
                    cmd.set_cover = !sts.covered;
                    state_next    = ST_IDLE;
                    s_ready_next  = 1'b1;
                end else if (!sts.covered) begin
                    state_next   = ST_IDLE;
                    s_ready_next = 1'b1;
                end else begin
                    cmd.clr_cover = 1'b1;
                    if (sts.keep) begin
                        cmd.div_start = 1'b1;
                        state_next    = ST_DIV;
                    end else begin
                        state_next   = ST_IDLE;
                        s_ready_next = 1'b1;
                    end
                end
            end
            ST_DIV: begin
                if (sts.div_done) begin
                    state_next = ST_LOAD;
                end
            end
            ST_LOAD: begin
                if (sts.out_free) begin
                    cmd.load_out = 1'b1;
                    state_next   = ST_IDLE;
                    s_ready_next = 1'b1;
                end
            end
            default: begin
                state_next   = ST_IDLE;
                s_ready_next = 1'b1;
            end
        endcase
    end

    // Hold state and the registered ready
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_IDLE;
            s_ready_reg <= 1'b1;
        end else begin
            state_reg   <= state_next;
            s_ready_reg <= s_ready_next;
        end
    end

    assign s_ready = s_ready_reg;

endmodule

// ===== design/occlusion_pulse_tachometer.sv =====
// Occlusion pulse tachometer, top level: ties controller to datapath.
// Depends on opt_pkg, opt_ctrl and opt_dpath.
//
// One sample is taken at a time. A sample that starts no division is done
// once it is captured and evaluated, and the next one may follow at once.
// A sample that ends a kept cover goes through capture, evaluation, 24
// steps of the radix-2 divider that finds rad/s and rpm side by side, and
// the load into the output register before the next is taken. A finished
// result waits in that register while the next samples are taken; only a
// second kept cover finding it still full has to wait for it to go out.
module occlusion_pulse_tachometer
    import opt_pkg::*;
(
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  cfg_wr_en,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_W-1:0]      cfg_wdata,
    input  logic                  s_valid,
    output logic                  s_ready,
    input  logic [DIST_W-1:0]     s_distance,
    input  logic [TIME_W-1:0]     s_time_ms,
    output logic                  m_valid,
    input  logic                  m_ready,
    output logic [TIME_W-1:0]     m_cover_ms,
    output logic [SPEED_W-1:0]    m_omega_q8,
    output logic [SPEED_W-1:0]    m_rpm_now_q4,
    output logic [SPEED_W-1:0]    m_rpm_prev_q4,
    output logic [SPEED_W-1:0]    m_rpm_min_q4,
    output logic                  m_prev_valid
);

    opt_cmd_t cmd;
    opt_sts_t sts;

    opt_ctrl u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .sts     (sts),
        .cmd     (cmd)
    );

    opt_dpath u_dpath (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .cfg_wr_en     (cfg_wr_en),
        .cfg_index     (cfg_index),
        .cfg_wdata     (cfg_wdata),
        .s_distance    (s_distance),
        .s_time_ms     (s_time_ms),
        .cmd           (cmd),
        .sts           (sts),
        .m_ready       (m_ready),
        .m_valid       (m_valid),
        .m_cover_ms    (m_cover_ms),
        .m_omega_q8    (m_omega_q8),
        .m_rpm_now_q4  (m_rpm_now_q4),
        .m_rpm_prev_q4 (m_rpm_prev_q4),
        .m_rpm_min_q4  (m_rpm_min_q4),
        .m_prev_valid  (m_prev_valid)
    );

    // Only one sample in flight
    a_one_in_flight: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_valid && s_ready) |=> !s_ready)
        else $error("second sample taken while one is in flight");

    // Never overwrite a result that has not been transferred
    a_no_overwrite: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.load_out |-> sts.out_free)
        else $error("result loaded over a pending result");

    // Division runs only while no sample is being taken
    a_div_busy: assert property (@(posedge aclk) disable iff (!aresetn)
        (cmd.div_start || sts.div_done) |-> !s_ready)
        else $error("divider active while ready for input");

    // A new result appears only out of the load step
    a_result_source: assert property (@(posedge aclk) disable iff (!aresetn)
        $rose(m_valid) |-> $past(cmd.load_out))
        else $error("result appeared without a load");

endmodule

// ===== verif/occlusion_pulse_tachometer_checker.sv =====
`timescale 1ns / 1ps
// Checker for the occlusion pulse tachometer. It mirrors the register writes,
// predicts one cover result per kept cover and compares each output transfer.
// Depends on opt_pkg.
module occlusion_pulse_tachometer_checker
    import opt_pkg::*;
(
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  cfg_wr_en,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_W-1:0]      cfg_wdata,
    input  logic                  s_valid,
    input  logic                  s_ready,
    input  logic [DIST_W-1:0]     s_distance,
    input  logic [TIME_W-1:0]     s_time_ms,
    input  logic                  m_valid,
    input  logic                  m_ready,
    input  logic [TIME_W-1:0]     m_cover_ms,
    input  logic [SPEED_W-1:0]    m_omega_q8,
    input  logic [SPEED_W-1:0]    m_rpm_now_q4,
    input  logic [SPEED_W-1:0]    m_rpm_prev_q4,
    input  logic [SPEED_W-1:0]    m_rpm_min_q4,
    input  logic                  m_prev_valid,
    output int                    error_count,
    output int                    pending
);

    typedef struct packed {
        logic [TIME_W-1:0]  cover_ms;
        logic [SPEED_W-1:0] omega_q8;
        logic [SPEED_W-1:0] rpm_now_q4;
        logic [SPEED_W-1:0] rpm_prev_q4;
        logic [SPEED_W-1:0] rpm_min_q4;
        logic               prev_valid;
    } cover_result_t;

    cover_result_t expected_covers[$];

    // Mirrored registers
    logic [DIST_W-1:0]  threshold;
    logic [15:0]        glitch_ms;
    logic [NUM_W-1:0]   rpm_num;
    logic [NUM_W-1:0]   omega_num;

    // Mirrored cover state
    logic               in_cover;
    logic [TIME_W-1:0]  entry_ms;
    logic               rpm_seen;
    logic [SPEED_W-1:0] last_rpm;

    initial begin
        error_count = 0;
        pending = 0;
    end

    // Truncating divide, saturated to the 16-bit speed range
    function automatic logic [SPEED_W-1:0] sat_quotient(input logic [NUM_W-1:0] num,
                                                        input logic [TIME_W-1:0] den);
        logic [TIME_W-1:0] q;
        q = TIME_W'(num) / den;
        return (q > TIME_W'(16'hFFFF)) ? 16'hFFFF : q[SPEED_W-1:0];
    endfunction

    task automatic flag_error(input string msg);
        $display("ERROR at %0t ns: %s", $time, msg);
        error_count++;
    endtask

    // Advance the cover state by one sample; queue a result for a kept cover
    task automatic track_sample(input logic [DIST_W-1:0] sample_dist,
                                input logic [TIME_W-1:0] now);
        cover_result_t res;
        logic [TIME_W-1:0] span;
        if (sample_dist < threshold) begin
            if (!in_cover) begin
                in_cover = 1'b1;
                entry_ms = now;
            end
        end else if (in_cover) begin
            in_cover = 1'b0;
            span = now - entry_ms;
            if (span > TIME_W'(glitch_ms)) begin
                res.cover_ms    = span;
                res.omega_q8    = sat_quotient(omega_num, span);
                res.rpm_now_q4  = sat_quotient(rpm_num, span);
                res.prev_valid  = rpm_seen;
                res.rpm_prev_q4 = rpm_seen ? last_rpm : '0;
                res.rpm_min_q4  = (rpm_seen && last_rpm < res.rpm_now_q4) ? last_rpm
                                                                          : res.rpm_now_q4;
                last_rpm = res.rpm_now_q4;
                rpm_seen = 1'b1;
                expected_covers.push_back(res);
            end
        end
    endtask

    // Compare one output transfer against the oldest queued cover
    task automatic check_cover();
        cover_result_t want;
        if (expected_covers.size() == 0) begin
            flag_error($sformatf("result with no cover pending, cover_ms %0d", m_cover_ms));
            return;
        end
        want = expected_covers.pop_front();
        if (m_cover_ms !== want.cover_ms)
            flag_error($sformatf("cover_ms got %0d want %0d", m_cover_ms, want.cover_ms));
        if (m_omega_q8 !== want.omega_q8)
            flag_error($sformatf("omega_q8 got %0d want %0d (cover %0d)",
                                 m_omega_q8, want.omega_q8, want.cover_ms));
        if (m_rpm_now_q4 !== want.rpm_now_q4)
            flag_error($sformatf("rpm_now_q4 got %0d want %0d (cover %0d)",
                                 m_rpm_now_q4, want.rpm_now_q4, want.cover_ms));
        if (m_rpm_prev_q4 !== want.rpm_prev_q4)
            flag_error($sformatf("rpm_prev_q4 got %0d want %0d",
                                 m_rpm_prev_q4, want.rpm_prev_q4));
        if (m_rpm_min_q4 !== want.rpm_min_q4)
            flag_error($sformatf("rpm_min_q4 got %0d want %0d",
                                 m_rpm_min_q4, want.rpm_min_q4));
        if (m_prev_valid !== want.prev_valid)
            flag_error($sformatf("prev_valid got %0b want %0b",
                                 m_prev_valid, want.prev_valid));
    endtask

    // Watch both channels and the register port at each rising edge
    always @(posedge aclk) begin
        if (!aresetn) begin
            threshold = RST_COVER_THRESHOLD;
            glitch_ms = RST_GLITCH_LIMIT;
            rpm_num   = RST_RPM_NUMERATOR;
            omega_num = RST_OMEGA_NUMERATOR;
            in_cover  = 1'b0;
            entry_ms  = '0;
            rpm_seen  = 1'b0;
            last_rpm  = '0;
            expected_covers.delete();
        end else begin
            if (m_valid && m_ready)
                check_cover();
            if (cfg_wr_en) begin
                case (cfg_index)
                    CFG_COVER_THRESHOLD: threshold = cfg_wdata[15:0];
                    CFG_GLITCH_LIMIT:    glitch_ms = cfg_wdata[15:0];
                    CFG_RPM_NUMERATOR:   rpm_num   = cfg_wdata[NUM_W-1:0];
                    CFG_OMEGA_NUMERATOR: omega_num = cfg_wdata[NUM_W-1:0];
                    default: ;
                endcase
            end
            if (s_valid && s_ready)
                track_sample(s_distance, s_time_ms);
        end
        pending = expected_covers.size();
    end

endmodule

// ===== verif/occlusion_pulse_tachometer_tb.sv =====
`timescale 1ns / 1ps
// Top of the occlusion pulse tachometer testbench: clock, reset, register
// writes, sample stimulus and output back-pressure, plus the final verdict.
// Depends on opt_pkg, occlusion_pulse_tachometer and its checker.
module occlusion_pulse_tachometer_tb
    import opt_pkg::*;
();

    localparam int RESET_CYCLES    = 7;
    localparam int SETTLE_CYCLES   = 40;
    localparam int HOLD_OFF_CYCLES = 300;
    localparam int PHASE_ITEMS     = 170;
    localparam int CYCLE_LIMIT     = 500000;

    logic                 aclk       = 1'b0;
    logic                 aresetn    = 1'b0;
    logic                 cfg_wr_en  = 1'b0;
    logic [CFG_IDX_W-1:0] cfg_index  = '0;
    logic [CFG_W-1:0]     cfg_wdata  = '0;
    logic                 s_valid    = 1'b0;
    logic [DIST_W-1:0]    s_distance = '0;
    logic [TIME_W-1:0]    s_time_ms  = '0;
    logic                 m_ready    = 1'b0;
    logic                 s_ready;
    logic                 m_valid;
    logic [TIME_W-1:0]    m_cover_ms;
    logic [SPEED_W-1:0]   m_omega_q8;
    logic [SPEED_W-1:0]   m_rpm_now_q4;
    logic [SPEED_W-1:0]   m_rpm_prev_q4;
    logic [SPEED_W-1:0]   m_rpm_min_q4;
    logic                 m_prev_valid;

    int error_count;
    int pending;
    int cycle_count = 0;

    // Stimulus controls shared with the receiver process
    bit quiet            = 1'b0;
    bit hold_off_request = 1'b0;

    // Settings in force, for shaping the random covers
    logic [DIST_W-1:0] cur_threshold = RST_COVER_THRESHOLD;
    logic [15:0]       cur_glitch    = RST_GLITCH_LIMIT;
    logic [TIME_W-1:0] clock_ms      = 32'd70000;

    always #1 aclk = ~aclk;

    occlusion_pulse_tachometer dut (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .cfg_wr_en     (cfg_wr_en),
        .cfg_index     (cfg_index),
        .cfg_wdata     (cfg_wdata),
        .s_valid       (s_valid),
        .s_ready       (s_ready),
        .s_distance    (s_distance),
        .s_time_ms     (s_time_ms),
        .m_valid       (m_valid),
        .m_ready       (m_ready),
        .m_cover_ms    (m_cover_ms),
        .m_omega_q8    (m_omega_q8),
        .m_rpm_now_q4  (m_rpm_now_q4),
        .m_rpm_prev_q4 (m_rpm_prev_q4),
        .m_rpm_min_q4  (m_rpm_min_q4),
        .m_prev_valid  (m_prev_valid)
    );

    occlusion_pulse_tachometer_checker u_checker (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .cfg_wr_en     (cfg_wr_en),
        .cfg_index     (cfg_index),
        .cfg_wdata     (cfg_wdata),
        .s_valid       (s_valid),
        .s_ready       (s_ready),
        .s_distance    (s_distance),
        .s_time_ms     (s_time_ms),
        .m_valid       (m_valid),
        .m_ready       (m_ready),
        .m_cover_ms    (m_cover_ms),
        .m_omega_q8    (m_omega_q8),
        .m_rpm_now_q4  (m_rpm_now_q4),
        .m_rpm_prev_q4 (m_rpm_prev_q4),
        .m_rpm_min_q4  (m_rpm_min_q4),
        .m_prev_valid  (m_prev_valid),
        .error_count   (error_count),
        .pending       (pending)
    );

    // Abort a hung run
    always @(posedge aclk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("Timeout after %0d cycles", cycle_count);
            $display("Testbench completed WITH ERRORS");
            $finish;
        end
    end

    // Drive m_ready: random idling, or one long hold-off when requested
    initial begin
        forever begin
            @(negedge aclk);
            if (hold_off_request) begin
                hold_off_request = 1'b0;
                m_ready <= 1'b0;
                repeat (HOLD_OFF_CYCLES - 1) @(negedge aclk);
            end else begin
                m_ready <= quiet || ($urandom_range(99) >= 8);
            end
        end
    end

    // Offer one sample and hold it until its transfer
    task automatic send_sample(input logic [DIST_W-1:0] sample_dist,
                               input logic [TIME_W-1:0] stamp);
        int gap;
        if (!quiet && $urandom_range(99) < 8) begin
            gap = $urandom_range(6, 1);
            @(negedge aclk);
            s_valid <= 1'b0;
            repeat (gap - 1) @(negedge aclk);
        end
        @(negedge aclk);
        s_valid    <= 1'b1;
        s_distance <= sample_dist;
        s_time_ms  <= stamp;
        @(posedge aclk);
        while (!s_ready) @(posedge aclk);
    endtask

    // Drop valid, wait for every queued cover, then let the block go idle
    task automatic settle();
        @(negedge aclk);
        s_valid <= 1'b0;
        while (pending != 0) @(posedge aclk);
        repeat (SETTLE_CYCLES) @(posedge aclk);
    endtask

    // Write all four registers once the block is idle
    task automatic load_settings(input logic [15:0] thr, input logic [15:0] glitch,
                                 input logic [NUM_W-1:0] rpm, input logic [NUM_W-1:0] omega);
        settle();
        @(negedge aclk);
        cfg_wr_en <= 1'b1;
        cfg_index <= CFG_COVER_THRESHOLD;
        cfg_wdata <= CFG_W'(thr);
        @(negedge aclk);
        cfg_index <= CFG_GLITCH_LIMIT;
        cfg_wdata <= CFG_W'(glitch);
        @(negedge aclk);
        cfg_index <= CFG_RPM_NUMERATOR;
        cfg_wdata <= rpm;
        @(negedge aclk);
        cfg_index <= CFG_OMEGA_NUMERATOR;
        cfg_wdata <= omega;
        @(negedge aclk);
        cfg_wr_en <= 1'b0;
        cur_threshold = thr;
        cur_glitch    = glitch;
    endtask

    // Distance below the threshold, edges now and then
    function automatic logic [DIST_W-1:0] covered_distance();
        if ($urandom_range(9) == 0)
            return $urandom_range(1) ? '0 : cur_threshold - 1'b1;
        return DIST_W'($urandom_range(cur_threshold - 1, 0));
    endfunction

    // Distance at or above the threshold, edges now and then
    function automatic logic [DIST_W-1:0] clear_distance();
        if ($urandom_range(9) == 0)
            return $urandom_range(1) ? 16'hFFFF : cur_threshold;
        return DIST_W'($urandom_range(16'hFFFF, cur_threshold));
    endfunction

    // Mostly well-formed covers around the glitch limit, some noise samples
    task automatic run_random_phase(input int n_items);
        int sent;
        int lead;
        int repeats;
        logic [TIME_W-1:0] entry;
        logic [TIME_W-1:0] span;
        sent = 0;
        while (sent < n_items) begin
            if ($urandom_range(99) < 15) begin
                send_sample(DIST_W'($urandom), $urandom);
                sent++;
            end else begin
                lead = $urandom_range(2);
                repeat (lead) begin
                    clock_ms += $urandom_range(20, 1);
                    send_sample(clear_distance(), clock_ms);
                end
                case ($urandom_range(9))
                    0, 1, 2:    span = TIME_W'(cur_glitch) + $urandom_range(3) - 1;
                    3, 4, 5, 6: span = TIME_W'(cur_glitch) + $urandom_range(500, 1);
                    7:          span = $urandom_range(100, 1);
                    default:    span = $urandom;
                endcase
                entry = clock_ms + $urandom_range(20, 1);
                send_sample(covered_distance(), entry);
                // repeated covered samples must keep the first entry time
                repeats = $urandom_range(3);
                repeat (repeats)
                    send_sample(covered_distance(), entry + ((span == 0) ? 0 : $urandom % span));
                send_sample(clear_distance(), entry + span);
                clock_ms = entry + span;
                sent += lead + repeats + 2;
            end
        end
    endtask

    // Main sequence
    initial begin
        repeat (RESET_CYCLES) @(negedge aclk);
        aresetn <= 1'b1;

        // Reset settings: idle sample, first cover, repeated cover, glitch edge
        send_sample(16'hFFFF, 32'd0);
        send_sample(16'd0, 32'd100);
        send_sample(16'd999, 32'd105);
        send_sample(16'd1000, 32'd200);
        send_sample(16'd500, 32'd300);
        send_sample(16'd2000, 32'd310);
        send_sample(16'd500, 32'd400);
        send_sample(16'd1000, 32'd411);
        // timestamp wrap, then the longest possible cover
        send_sample(16'd0, 32'hFFFF_FFF0);
        send_sample(16'hFFFF, 32'h0000_0010);
        send_sample(16'd0, 32'd5000);
        send_sample(16'd1000, 32'd4999);

        // Widest threshold, no glitch filter, saturating rpm, zero omega
        load_settings(16'hFFFF, 16'd0, 24'hFF_FFFF, 24'd0);
        send_sample(16'hFFFE, 32'd7);
        send_sample(16'hFFFF, 32'd8);
        send_sample(16'd0, 32'd20);
        send_sample(16'hFFFF, 32'd20);
        send_sample(16'hFFFF, 32'd30);

        // Zero threshold: nothing ever covers
        load_settings(16'd0, 16'hFFFF, 24'd1, 24'hFF_FFFF);
        send_sample(16'd0, 32'd40);
        send_sample(16'd0, 32'd50);

        // Longest glitch limit: drop at the limit, keep one past it
        load_settings(16'd1, 16'hFFFF, 24'd0, 24'hFF_FFFF);
        send_sample(16'd0, 32'd100);
        send_sample(16'd1, 32'd65635);
        send_sample(16'd0, 32'd200);
        send_sample(16'd1, 32'd65736);

        // Random phases over several settings
        for (int phase = 0; phase < 5; phase++) begin
            case (phase)
                0: load_settings(RST_COVER_THRESHOLD, RST_GLITCH_LIMIT,
                                 RST_RPM_NUMERATOR, RST_OMEGA_NUMERATOR);
                1: load_settings(16'hFFFF, 16'd0, 24'hFF_FFFF, 24'hFF_FFFF);
                2: load_settings(16'd1, 16'hFFFF, 24'd1, 24'd1);
                default: load_settings(16'($urandom_range(16'hFFFF, 1)),
                                       16'($urandom_range(300)),
                                       24'($urandom_range(24'hFF_FFFF, 1)),
                                       24'($urandom_range(24'hFF_FFFF, 1)));
            endcase
            quiet = (phase == 1);
            hold_off_request = !quiet;
            run_random_phase(PHASE_ITEMS);
        end

        settle();
        if (error_count == 0)
            $display("Testbench completed without errors");
        else
            $display("Testbench completed WITH ERRORS");
        $finish;
    end

endmodule

// ===== occlusion_pulse_tachometer.f =====
design/opt_pkg.sv
design/opt_div.sv
design/opt_dpath.sv
design/opt_ctrl.sv
design/occlusion_pulse_tachometer.sv
verif/occlusion_pulse_tachometer_checker.sv
verif/occlusion_pulse_tachometer_tb.sv
